@@ hdl/lcdw_pkg.sv @@
`timescale 1ns / 1ps

package lcdw_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 135;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int KIND_W  = 2;
    localparam int COORD_W = 8;
    localparam int COLOR_W = 16;
    localparam int ADDR_W  = 15;

    localparam logic [KIND_W-1:0] KIND_SET_WINDOW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_PIXEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW_POINT  = 2'd2;

    typedef enum logic {
        ST_CLEAR,
        ST_READY
    } ctrl_state_t;

    typedef struct packed {
        logic clear_en;
        logic item_en;
    } lcdw_cmd_t;

    typedef struct packed {
        logic clear_last;
    } lcdw_status_t;

endpackage

@@ hdl/lcdw_ctrl.sv @@
`timescale 1ns / 1ps

module lcdw_ctrl
    import lcdw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output lcdw_cmd_t    cmd,
    input  lcdw_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.clear_en = 1'b0;
        cmd.item_en  = 1'b0;
        busy         = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                busy         = 1'b1;
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_READY;
                end
            end
            ST_READY:
            begin
                cmd.item_en = start;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/lcdw_datapath.sv @@
`timescale 1ns / 1ps

module lcdw_datapath
    import lcdw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lcdw_cmd_t          cmd,
    output lcdw_status_t       status,
    input  logic [KIND_W-1:0]  kind,
    input  logic [COORD_W-1:0] col_start,
    input  logic [COORD_W-1:0] row_start,
    input  logic [COORD_W-1:0] col_end,
    input  logic [COORD_W-1:0] row_end,
    input  logic [COLOR_W-1:0] pixel_color,
    output logic               done,
    output logic               stored,
    output logic [ADDR_W-1:0]  store_address,
    output logic               window_open
);

    logic [COLOR_W-1:0] frame_mem [PIXEL_COUNT];

    logic [ADDR_W-1:0]  clr_addr_reg;

    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  wp_next;
    logic [COORD_W-1:0] width_reg;
    logic [COORD_W-1:0] width_next;
    logic [COORD_W-1:0] height_reg;
    logic [COORD_W-1:0] height_next;
    logic [COORD_W-1:0] col_step_reg;
    logic [COORD_W-1:0] col_step_next;
    logic [COORD_W:0]   row_step_reg;
    logic [COORD_W:0]   row_step_next;

    logic               done_reg;
    logic               stored_reg;
    logic               stored_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic               open_reg;
    logic               open_next;

    logic               wr_en_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [COLOR_W-1:0] wr_data_reg;

    logic               win_ok;
    logic               point_ok;
    logic               open_now;
    logic [ADDR_W-1:0]  start_addr;

    assign status.clear_last = (clr_addr_reg == ADDR_W'(PIXEL_COUNT - 1));

    assign win_ok   = (col_end >= col_start) && (row_end >= row_start)
                   && (ADDR_W'(col_end) < ADDR_W'(SCREEN_WIDTH))
                   && (ADDR_W'(row_end) < ADDR_W'(SCREEN_HEIGHT));
    assign point_ok = (ADDR_W'(col_start) < ADDR_W'(SCREEN_WIDTH))
                   && (ADDR_W'(row_start) < ADDR_W'(SCREEN_HEIGHT));
    assign open_now = (width_reg != '0) || (height_reg != '0);
    assign start_addr = ADDR_W'(ADDR_W'(row_start) * ADDR_W'(SCREEN_WIDTH))
                      + ADDR_W'(col_start);

    always_comb
    begin
        wp_next       = wp_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        col_step_next = col_step_reg;
        row_step_next = row_step_reg;
        stored_next   = 1'b0;
        addr_next     = '0;
        if (cmd.item_en)
        begin
            case (kind)
                KIND_SET_WINDOW:
                begin
                    if (win_ok)
                    begin
                        wp_next     = start_addr;
                        width_next  = col_end - col_start;
                        height_next = row_end - row_start;
                    end
                    else
                    begin
                        wp_next     = '0;
                        width_next  = '0;
                        height_next = '0;
                    end
                    col_step_next = '0;
                    row_step_next = '0;
                end
                KIND_WRITE_PIXEL:
                begin
                    if (open_now)
                    begin
                        if (row_step_reg <= {1'b0, height_reg})
                        begin
                            if (wp_reg < ADDR_W'(PIXEL_COUNT))
                            begin
                                stored_next = 1'b1;
                                addr_next   = wp_reg;
                            end
                            if (col_step_reg == width_reg)
                            begin
                                wp_next       = wp_reg + (ADDR_W'(SCREEN_WIDTH)
                                              - ADDR_W'(width_reg));
                                col_step_next = '0;
                                row_step_next = row_step_reg + 1'b1;
                            end
                            else
                            begin
                                wp_next       = wp_reg + 1'b1;
                                col_step_next = col_step_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            // window exhausted
                            wp_next       = '0;
                            width_next    = '0;
                            height_next   = '0;
                            col_step_next = '0;
                            row_step_next = '0;
                        end
                    end
                end
                KIND_DRAW_POINT:
                begin
                    if (point_ok)
                    begin
                        stored_next = 1'b1;
                        addr_next   = start_addr;
                    end
                end
                default:
                begin
                end
            endcase
        end
        open_next = (width_next != '0) || (height_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            col_step_reg <= '0;
            row_step_reg <= '0;
            done_reg     <= 1'b0;
            wr_en_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            wp_reg       <= wp_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_step_reg <= col_step_next;
            row_step_reg <= row_step_next;
            done_reg     <= cmd.item_en;
            wr_en_reg    <= stored_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_en)
        begin
            stored_reg <= stored_next;
            addr_reg   <= addr_next;
            open_reg   <= open_next;
        end
        wr_addr_reg <= addr_next;
        wr_data_reg <= pixel_color;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            frame_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en_reg)
        begin
            frame_mem[wr_addr_reg] <= wr_data_reg;
        end
    end

    assign done          = done_reg;
    assign stored        = stored_reg;
    assign store_address = addr_reg;
    assign window_open   = open_reg;

endmodule

@@ hdl/lcd_window_pixel_writer.sv @@
`timescale 1ns / 1ps

// After reset the block holds busy high while it clears the frame memory to
// background, one pixel a cycle; start is ignored until busy falls and busy then
// stays low. From then on one item is taken every cycle: each item's result
// appears on stored, store_address and window_open together with done in the
// cycle after the transfer, and the pixel reaches frame memory through a
// registered write port in the cycle after that. The receiver cannot stall, so
// results must be taken in the cycle that done is high.
module lcd_window_pixel_writer
    import lcdw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [KIND_W-1:0]  kind,
    input  logic [COORD_W-1:0] col_start,
    input  logic [COORD_W-1:0] row_start,
    input  logic [COORD_W-1:0] col_end,
    input  logic [COORD_W-1:0] row_end,
    input  logic [COLOR_W-1:0] pixel_color,
    output logic               done,
    output logic               stored,
    output logic [ADDR_W-1:0]  store_address,
    output logic               window_open
);

    lcdw_cmd_t    cmd;
    lcdw_status_t status;

    lcdw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    lcdw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .col_start     (col_start),
        .row_start     (row_start),
        .col_end       (col_end),
        .row_end       (row_end),
        .pixel_color   (pixel_color),
        .done          (done),
        .stored        (stored),
        .store_address (store_address),
        .window_open   (window_open)
    );

endmodule

@@ hdl/lcdw_checker.sv @@
`timescale 1ns / 1ps

module lcdw_checker
    import lcdw_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [KIND_W-1:0]  kind,
    input logic [COORD_W-1:0] col_start,
    input logic [COORD_W-1:0] row_start,
    input logic [COORD_W-1:0] col_end,
    input logic [COORD_W-1:0] row_end,
    input logic [COLOR_W-1:0] pixel_color,
    input logic               done,
    input logic               stored,
    input logic [ADDR_W-1:0]  store_address,
    input logic               window_open
);

    // every transfer gives exactly one result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("transfer without result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without transfer");

    // clearing happens once after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !stored) |-> (store_address == '0))
        else $error("address without store");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && stored) |-> (store_address < ADDR_W'(PIXEL_COUNT)))
        else $error("store address off screen");

endmodule

bind lcd_window_pixel_writer lcdw_checker u_checker (.*);
